[rtl/core/lkvc_pkg.sv]
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic
    {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed
    {
        logic cmp_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage

[rtl/core/lkvc_cell.sv]
`timescale 1ns / 1ps

module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic             evict,
    input  logic [KEY_W-1:0] cmp_key,
    input  entry_t           left,
    output entry_t           entry,
    input  logic             hit_in,
    output logic             hit_out,
    input  logic [VAL_W-1:0] hit_value_in,
    output logic [VAL_W-1:0] hit_value_out
);

    logic             valid_reg;
    logic             valid_next;
    logic             match_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             take_left;

    // a more recent hit keeps this cell in place, otherwise it ages by one position
    assign take_left = ctrl.shift_en && !hit_in;

    always_comb
    begin
        valid_next = take_left ? left.valid : valid_reg;
        if (evict)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.cmp_en)
            begin
                match_reg <= valid_reg && (key_reg == cmp_key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_left)
        begin
            key_reg   <= left.key;
            value_reg <= left.value;
        end
    end

    assign entry.valid   = valid_reg;
    assign entry.key     = key_reg;
    assign entry.value   = value_reg;
    assign hit_out       = hit_in | match_reg;
    assign hit_value_out = match_reg ? value_reg : hit_value_in;

endmodule

[rtl/core/lru_key_value_cache.sv]
`timescale 1ns / 1ps

// fully associative key/value cache with least-recently-used replacement
// input stream: s_axis_tdata = {write_value, lookup_key}, s_axis_tuser = kind
//   (0 get, 1 put). a get returns one transfer on the output stream with
//   m_axis_tuser = found and m_axis_tdata = stored value, or all ones on a miss.
//   a put returns nothing.
// entries sit in a row of cells ordered by recency, cell 0 most recent. an access
//   compares the key in every cell in the compare state, then in the update state the hit
//   entry (or the new one) moves into cell 0 and the cells ahead of it slide down.
// a get result is registered in the update state that follows the compare state.
// the next item is taken during the update (shift) state of the cell row.
// capacity is written through cfg_we/cfg_wdata; the user must write it only while the
//   block is idle, which the block does not enforce. values above 16 act as 16. a put
//   that leaves more entries than capacity drops the least recent one.
// reset empties the cache and sets capacity to 16; no clearing pass is needed.
// when the output receiver stalls with a result still held, the shift cycle of
//   the next item waits, and no further input is taken until the result leaves.

module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CAP_W-1:0]       cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [KEY_W+VAL_W-1:0] s_axis_tdata,  // lookup_key, write_value
    input  logic                   s_axis_tuser,  // kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [VAL_W-1:0]       m_axis_tdata,  // read_value
    output logic                   m_axis_tuser   // found
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    state_t           state_reg;
    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] cnt_reg;
    kind_t            kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] wval_reg;
    logic             out_valid_reg;
    logic             found_reg;
    logic [VAL_W-1:0] rdval_reg;

    logic             upd_go;
    logic             rd_load;
    logic             accept;
    logic             found;
    logic [VAL_W-1:0] hit_value;
    logic             is_put;
    logic [CNT_W-1:0] cnt_ins;
    logic [CMP_W-1:0] cap_sat;
    logic             evict;
    logic [IDX_W-1:0] evict_idx;
    cell_ctrl_t       ctrl;

    entry_t           chain [ENTRIES+1];
    logic             hit_chain [ENTRIES+1];
    logic [VAL_W-1:0] hv_chain [ENTRIES+1];

    // the update cycle waits while a get result is still unread
    assign upd_go        = !(out_valid_reg && !m_axis_tready);
    assign s_axis_tready = (state_reg == ST_IDLE) || ((state_reg == ST_UPD) && upd_go);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign found     = hit_chain[ENTRIES];
    assign hit_value = hv_chain[ENTRIES];
    assign is_put    = (kind_reg == KIND_PUT);
    assign rd_load   = (state_reg == ST_UPD) && upd_go && !is_put;

    assign ctrl.cmp_en   = (state_reg == ST_CMP);
    assign ctrl.shift_en = (state_reg == ST_UPD) && upd_go && (is_put || found);

    always_comb
    begin
        cnt_ins = cnt_reg;
        if (is_put && !found && (cnt_reg != CNT_W'(ENTRIES)))
        begin
            cnt_ins = cnt_reg + CNT_W'(1);
        end
        cap_sat = (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_reg);
        evict   = ctrl.shift_en && is_put && (CMP_W'(cnt_ins) > cap_sat);
        // after the shift the least recent valid entry sits at count - 1
        evict_idx = IDX_W'(cnt_ins - CNT_W'(1));
    end

    // new or refreshed entry enters at the head of the row
    assign chain[0].valid = 1'b1;
    assign chain[0].key   = key_reg;
    assign chain[0].value = is_put ? wval_reg : hit_value;
    assign hit_chain[0]   = 1'b0;
    assign hv_chain[0]    = '1;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lkvc_cell u_cell
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .evict         (evict && (evict_idx == IDX_W'(i))),
            .cmp_key       (key_reg),
            .left          (chain[i]),
            .entry         (chain[i+1]),
            .hit_in        (hit_chain[i]),
            .hit_out       (hit_chain[i+1]),
            .hit_value_in  (hv_chain[i]),
            .hit_value_out (hv_chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_GET;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (accept)
            begin
                kind_reg <= kind_t'(s_axis_tuser);
            end
            if (rd_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (upd_go)
                    begin
                        if (ctrl.shift_en)
                        begin
                            cnt_reg <= evict ? cnt_ins - CNT_W'(1) : cnt_ins;
                        end
                        state_reg <= accept ? ST_CMP : ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= s_axis_tdata[KEY_W-1:0];
            wval_reg <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
        end
        if (rd_load)
        begin
            found_reg <= found;
            rdval_reg <= hit_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = rdval_reg;
    assign m_axis_tuser  = found_reg;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import lkvc_pkg::*;

    localparam int SETTLE_CYCLES = 8;

    typedef struct
    {
        kind_t            kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } cache_op_t;

    typedef struct
    {
        logic             found;
        logic [VAL_W-1:0] value;
    } read_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CAP_W-1:0]       cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [KEY_W+VAL_W-1:0] s_axis_tdata = '0;  // lookup_key, write_value
    logic                   s_axis_tuser = 1'b0;  // kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [VAL_W-1:0]       m_axis_tdata;  // read_value
    logic                   m_axis_tuser;  // found

    lru_key_value_cache uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cache_op_t    pending_ops[$];
    read_result_t expected_reads[$];
    cache_op_t    cur_op;
    int           error_count = 0;
    int           send_gap = 0;
    int           send_calm = 0;
    int           ready_stall = 0;
    int           ready_calm = 0;
    int           hold_left = 0;
    int           reads_seen = 0;

    // shadow of the cache contents; rank 0 is most recent
    logic [KEY_W-1:0] shadow_key[ENTRIES];
    logic [VAL_W-1:0] shadow_val[ENTRIES];
    bit               shadow_valid[ENTRIES];
    int               shadow_rank[ENTRIES];
    int               shadow_count = 0;
    int               shadow_cap = 16;

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = 0;
        end
        forever #5 clk = ~clk;
    end

    function automatic int pick_pause(inout int calm_run);
        int roll;
        if (calm_run > 0)
        begin
            calm_run--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            calm_run = $urandom_range(10, 40);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic int lru_find(logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && shadow_key[i] == k)
                return i;
        return -1;
    endfunction

    task automatic lru_touch(int slot);
        int r;
        r = shadow_rank[slot];
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && i != slot && shadow_rank[i] < r)
                shadow_rank[i]++;
        shadow_rank[slot] = 0;
    endtask

    task automatic lru_evict_oldest();
        int victim;
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
                victim = i;
        if (victim >= 0)
        begin
            shadow_valid[victim] = 1'b0;
            shadow_rank[victim]  = 0;
            shadow_count--;
        end
    endtask

    task automatic lru_insert(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        int slot;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (!shadow_valid[i] && slot < 0)
                slot = i;
        if (slot >= 0)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i])
                    shadow_rank[i]++;
            shadow_key[slot]   = k;
            shadow_val[slot]   = v;
            shadow_valid[slot] = 1'b1;
            shadow_rank[slot]  = 0;
            shadow_count++;
        end
    endtask

    task automatic lru_access(cache_op_t op);
        int           slot;
        read_result_t res;
        slot = lru_find(op.key);
        if (op.kind == KIND_GET)
        begin
            if (slot >= 0)
            begin
                lru_touch(slot);
                res.found = 1'b1;
                res.value = shadow_val[slot];
            end
            else
            begin
                res.found = 1'b0;
                res.value = '1;
            end
            expected_reads.push_back(res);
        end
        else
        begin
            if (slot >= 0)
            begin
                shadow_val[slot] = op.value;
                lru_touch(slot);
            end
            else
            begin
                if (shadow_count >= ENTRIES)
                    lru_evict_oldest();
                lru_insert(op.key, op.value);
            end
            if (shadow_count > shadow_cap)
                lru_evict_oldest();
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                lru_access(cur_op);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_ops.size() != 0)
                begin
                    cur_op = pending_ops.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_op.value, cur_op.key};
                    s_axis_tuser  <= cur_op.kind;
                    send_gap = pick_pause(send_calm);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_reads.size() == 0)
                begin
                    $error("unexpected read result: found %0d value %h",
                           m_axis_tuser, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    read_result_t want;
                    want = expected_reads.pop_front();
                    if (m_axis_tuser !== want.found)
                    begin
                        $error("found mismatch: expected %0d, actual %0d",
                               want.found, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata !== want.value)
                    begin
                        $error("read_value mismatch: expected %h, actual %h",
                               want.value, m_axis_tdata);
                        error_count++;
                    end
                end
                reads_seen++;
                // long back-pressure so the input side fills up and stalls
                if (reads_seen % 200 == 60)
                    hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (ready_stall > 0)
            begin
                ready_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                ready_stall = pick_pause(ready_calm);
            end
        end
    end

    task automatic queue_op(kind_t kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        cache_op_t op;
        op.kind  = kind;
        op.key   = key;
        op.value = value;
        pending_ops.push_back(op);
    endtask

    // sampled on the falling edge so the sender's bookkeeping has settled
    task automatic wait_idle();
        @(negedge clk);
        while (pending_ops.size() != 0 || s_axis_tvalid || expected_reads.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_cap = (cap > ENTRIES) ? ENTRIES : cap;
    endtask

    // mostly keys from a small pool so hits, updates and evictions happen
    task automatic queue_random(int count, int pool_size);
        logic [KEY_W-1:0] pool[];
        logic [KEY_W-1:0] k;
        kind_t            kind;
        pool = new[pool_size];
        for (int i = 0; i < pool_size; i++)
            pool[i] = $urandom();
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 8)
                k = pool[$urandom_range(0, pool_size - 1)];
            else
                k = $urandom();
            kind = ($urandom_range(0, 99) < 45) ? KIND_PUT : KIND_GET;
            queue_op(kind, k, $urandom());
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_capacity(5'd16);
        // empty cache, extreme keys and values, overwrite on hit
        queue_op(KIND_GET, 32'h0000_0000, 32'h0000_0000);
        queue_op(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_op(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_op(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_op(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_op(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(KIND_GET, 32'h0000_0000, 32'h0000_0000);
        queue_op(KIND_PUT, 32'h0000_0000, 32'h1234_5678);
        queue_op(KIND_GET, 32'h0000_0000, 32'h0000_0000);
        queue_op(KIND_GET, 32'h0000_0001, 32'h0000_0000);

        // zero capacity: every put drops the least recent entry, resident ones included
        write_capacity(5'd0);
        queue_op(KIND_PUT, 32'h0000_0005, 32'hA5A5_A5A5);
        queue_op(KIND_GET, 32'h0000_0005, 32'h0000_0000);
        queue_op(KIND_PUT, 32'h8000_0000, 32'h0000_0001);
        queue_op(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_random(20, 4);

        // above the slot count acts as full size; pool wider than the cache
        write_capacity(5'd31);
        queue_random(120, 24);

        // lowered below the current count: one eviction per put
        write_capacity(5'd2);
        queue_random(60, 20);

        write_capacity(5'd1);
        queue_random(60, 4);

        write_capacity(5'd16);
        queue_random(150, 20);

        write_capacity(5'd20);
        queue_random(60, 12);

        write_capacity(5'd7);
        queue_random(80, 10);

        wait_idle();
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
